>>> design/gas_pkg.sv
// Shared types, register indexes and score helpers for the global alignment score block.
`timescale 1ns / 1ps

package gas_pkg;

    localparam int SCORE_W = 12;
    localparam int K_W     = 11;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic signed [SCORE_W:0]   wide_score_t;

    localparam score_t SCORE_MIN = -12'sd2048;
    localparam score_t SCORE_MAX = 12'sd2047;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_BONUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_PENALTY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_PENALTY      = 2'd2;

    typedef struct packed {
        logic [3:0] match_bonus;
        logic [3:0] mismatch_penalty;
        logic [3:0] gap_penalty;
    } cfg_t;

    typedef struct packed {
        logic       clear;
        logic       wr;
        logic [7:0] symbol;
    } load_t;

    // One reference symbol travelling down the chain, with the scores of the row above.
    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       first;
        logic       hold;
        logic       too_long;
        score_t     up;
        score_t     diag;
    } beat_t;

    // Edge score -k*gap, clamped at the bottom of the score range.
    function automatic score_t edge_score(input logic [K_W-1:0] k, input logic [3:0] g);
        logic [K_W+3:0]      p;
        logic signed [K_W+4:0] n;
        p = (K_W+4)'(k) * (K_W+4)'(g);
        n = -$signed({1'b0, p});
        if (p > (K_W+4)'(2048))
            return SCORE_MIN;
        else
            return score_t'(n);
    endfunction

    function automatic score_t sat_score(input wide_score_t v);
        if (v < wide_score_t'(SCORE_MIN))
            return SCORE_MIN;
        else if (v > wide_score_t'(SCORE_MAX))
            return SCORE_MAX;
        else
            return score_t'(v);
    endfunction

endpackage

>>> design/gas_if.sv
// Channel interfaces: input items, results and configuration writes.
`timescale 1ns / 1ps

interface gas_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, func, symbol, last, input ready);
    modport sink   (input valid, func, symbol, last, output ready);
endinterface

interface gas_result_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] score;
    logic               too_long;

    modport source (output valid, score, too_long, input ready);
    modport sink   (input valid, score, too_long, output ready);
endinterface

interface gas_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/gas_cell.sv
// One cell of the systolic row: holds one query symbol and the score of its row.
`timescale 1ns / 1ps

module gas_cell
    import gas_pkg::*;
#(
    parameter int IDX = 1
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  cfg_t  cfg,
    input  load_t load,
    input  logic  sel,
    input  logic  in_valid,
    input  beat_t in_beat,
    output logic  out_valid,
    output beat_t out_beat
);

    logic [7:0]  sym_reg;
    logic        qvalid_reg;
    logic        qvalid_next;
    score_t      h_reg;
    logic        valid_reg;
    beat_t       beat_reg;
    beat_t       beat_next;

    score_t      left;
    wide_score_t diag_term;
    wide_score_t up_term;
    wide_score_t left_term;
    wide_score_t best;
    score_t      new_score;
    logic        update;

    always_comb
    begin
        left = in_beat.first ? edge_score(K_W'(IDX), cfg.gap_penalty) : h_reg;
        if (in_beat.symbol == sym_reg)
            diag_term = wide_score_t'(in_beat.diag) + wide_score_t'({1'b0, cfg.match_bonus});
        else
            diag_term = wide_score_t'(in_beat.diag)
                        - wide_score_t'({1'b0, cfg.mismatch_penalty});
        up_term   = wide_score_t'(in_beat.up) - wide_score_t'({1'b0, cfg.gap_penalty});
        left_term = wide_score_t'(left) - wide_score_t'({1'b0, cfg.gap_penalty});
        best = up_term;
        if (left_term > best)
            best = left_term;
        if (diag_term > best)
            best = diag_term;
        new_score = sat_score(best);
        update    = in_valid && qvalid_reg && !in_beat.hold;

        beat_next = in_beat;
        // Cells past the end of the query only forward the bottom score.
        priority if (!qvalid_reg)
        begin
            beat_next.up   = in_beat.up;
            beat_next.diag = in_beat.diag;
        end
        else if (in_beat.hold)
        begin
            beat_next.up   = h_reg;
            beat_next.diag = h_reg;
        end
        else
        begin
            beat_next.up   = new_score;
            beat_next.diag = left;
        end

        qvalid_next = qvalid_reg;
        if (load.clear)
            qvalid_next = 1'b0;
        if (load.wr && sel)
            qvalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qvalid_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            qvalid_reg <= qvalid_next;
            if (en)
                valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.wr && sel)
            sym_reg <= load.symbol;
        if (en)
            beat_reg <= beat_next;
        if (en && update)
            h_reg <= new_score;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

>>> design/global_alignment_score.sv
// Top level of the global alignment score block: input stage, cell row and result register.
`timescale 1ns / 1ps

// Needleman-Wunsch global alignment score with a linear gap penalty. Load items (func 0) write
// the query, one symbol per beat, into a row of MAX_LEN cells; the beat marked last ends the
// query. Stream items (func 1) bring the reference one symbol per beat, and a new stream beat
// is taken every cycle unless the row is stalled. Each symbol walks down the cell row one cell
// per cycle while the row is not stalled, so the input register and the MAX_LEN cells hold up
// to MAX_LEN+1 reference symbols in flight. The score for the stream beat marked last passes
// through the input register and the MAX_LEN cells to the result register. The row stalls only
// while a finished score reaches its end and the previous result still waits to be taken. A
// load beat is taken only once the row has drained, so the first load after a stream waits
// until the last stream beat has left the last cell. Scores saturate to 12 bits signed;
// symbols beyond MAX_LEN on either sequence are dropped and set too_long until the next query
// starts.
module global_alignment_score
    import gas_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    gas_item_if.sink      item,
    gas_result_if.source  result,
    gas_cfg_if.sink       cfg
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int FLY_W = $clog2(MAX_LEN + 2);

    cfg_t             cfg_reg;
    logic [CNT_W-1:0] query_count_reg;
    logic [CNT_W-1:0] query_count_next;
    logic [CNT_W-1:0] ref_count_reg;
    logic [CNT_W-1:0] ref_count_next;
    logic             flag_reg;
    logic             flag_next;
    logic             aligning_reg;
    logic             aligning_next;
    logic [FLY_W-1:0] inflight_reg;
    logic [FLY_W-1:0] inflight_next;
    logic             head_valid_reg;
    beat_t            head_reg;
    beat_t            head_next;
    logic             out_valid_reg;
    score_t           out_score_reg;
    logic             out_too_long_reg;

    logic             enable;
    logic             accept;
    logic             load_go;
    logic             stream_go;
    logic             tail_done;
    logic             hold;
    logic [CNT_W-1:0] count_base;
    load_t            load;
    logic [MAX_LEN-1:0] load_sel;

    logic [MAX_LEN:0] chain_valid;
    beat_t            chain_beat [MAX_LEN+1];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_bonus      <= 4'd1;
            cfg_reg.mismatch_penalty <= 4'd1;
            cfg_reg.gap_penalty      <= 4'd1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MATCH_BONUS:      cfg_reg.match_bonus      <= cfg.data;
                REG_MISMATCH_PENALTY: cfg_reg.mismatch_penalty <= cfg.data;
                REG_GAP_PENALTY:      cfg_reg.gap_penalty      <= cfg.data;
                default: ;
            endcase
        end
    end

    // The row stalls only when a finished score reaches the end while the last one waits.
    assign tail_done = chain_valid[MAX_LEN] && chain_beat[MAX_LEN].last;
    assign enable    = !(tail_done && out_valid_reg && !result.ready);

    assign item.ready = enable && (item.func || (inflight_reg == '0));
    assign accept     = item.valid && item.ready;
    assign load_go    = accept && !item.func;
    assign stream_go  = accept && item.func && aligning_reg;
    assign hold       = ref_count_reg >= CNT_W'(MAX_LEN);
    assign count_base = aligning_reg ? '0 : query_count_reg;

    always_comb
    begin
        load.clear  = load_go && aligning_reg;
        load.wr     = load_go && (count_base < CNT_W'(MAX_LEN));
        load.symbol = item.symbol;
        for (int i = 0; i < MAX_LEN; i++)
            load_sel[i] = (count_base == CNT_W'(i));
    end

    always_comb
    begin
        query_count_next = query_count_reg;
        ref_count_next   = ref_count_reg;
        flag_next        = flag_reg;
        aligning_next    = aligning_reg;

        head_next.symbol   = item.symbol;
        head_next.last     = item.last;
        head_next.first    = (ref_count_reg == '0);
        head_next.hold     = hold;
        head_next.too_long = flag_reg || hold;
        head_next.diag     = edge_score(K_W'(ref_count_reg), cfg_reg.gap_penalty);
        head_next.up       = edge_score(K_W'(ref_count_reg) + K_W'(1), cfg_reg.gap_penalty);

        if (load_go)
        begin
            if (aligning_reg)
                flag_next = 1'b0;
            if (load.wr)
                query_count_next = count_base + CNT_W'(1);
            else
            begin
                query_count_next = count_base;
                flag_next        = 1'b1;
            end
            aligning_next = item.last;
            if (item.last)
                ref_count_next = '0;
            if (aligning_reg && !item.last)
                ref_count_next = '0;
        end
        else if (stream_go)
        begin
            if (hold)
                flag_next = 1'b1;
            else
                ref_count_next = ref_count_reg + CNT_W'(1);
            if (item.last)
                ref_count_next = '0;
        end

        inflight_next = inflight_reg + FLY_W'(stream_go)
                        - FLY_W'(chain_valid[MAX_LEN] && enable);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_count_reg <= '0;
            ref_count_reg   <= '0;
            flag_reg        <= 1'b0;
            aligning_reg    <= 1'b0;
            inflight_reg    <= '0;
            head_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            query_count_reg <= query_count_next;
            ref_count_reg   <= ref_count_next;
            flag_reg        <= flag_next;
            aligning_reg    <= aligning_next;
            inflight_reg    <= inflight_next;
            if (enable)
                head_valid_reg <= stream_go;
            if (tail_done && enable)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
            head_reg <= head_next;
        if (tail_done && enable)
        begin
            out_score_reg    <= chain_beat[MAX_LEN].up;
            out_too_long_reg <= chain_beat[MAX_LEN].too_long;
        end
    end

    assign chain_valid[0] = head_valid_reg;
    assign chain_beat[0]  = head_reg;

    for (genvar g = 1; g <= MAX_LEN; g++)
    begin : g_cell
        gas_cell #(
            .IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (enable),
            .cfg       (cfg_reg),
            .load      (load),
            .sel       (load_sel[g-1]),
            .in_valid  (chain_valid[g-1]),
            .in_beat   (chain_beat[g-1]),
            .out_valid (chain_valid[g]),
            .out_beat  (chain_beat[g])
        );
    end

    assign result.valid    = out_valid_reg;
    assign result.score    = out_score_reg;
    assign result.too_long = out_too_long_reg;

`ifndef SYNTHESIS
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= FLY_W'(MAX_LEN + 1))
        else $error("more beats in the cell row than it has stages");

    a_load_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load_go |-> (inflight_reg == '0) && !chain_valid[MAX_LEN])
        else $error("query load taken while reference beats are in flight");

    a_result_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_done && enable) |=> out_valid_reg)
        else $error("finished score did not reach the result register");

    a_query_bound: assert property (@(posedge clk) disable iff (!rst_n)
        query_count_reg <= CNT_W'(MAX_LEN))
        else $error("query count beyond the row length");

    a_phase_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(aligning_reg) |-> $past(load_go))
        else $error("aligning phase ended without a query load");
`endif

endmodule

>>> tb/gas_tb_pkg.sv
// Testbench codes and records shared by the alignment score checker and the testbench top.
`timescale 1ns / 1ps

package gas_tb_pkg;

    import gas_pkg::*;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_STREAM = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] symbol;
        logic       last;
    } item_t;

    typedef struct packed {
        score_t score;
        logic   too_long;
    } score_rec_t;

endpackage

>>> tb/gas_score_checker.sv
// Channel monitor that predicts alignment scores and compares them with the block's results.
`timescale 1ns / 1ps

module gas_score_checker
    import gas_pkg::*;
    import gas_tb_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    gas_item_if   item,
    gas_result_if result,
    gas_cfg_if    cfg,
    output int    mismatches,
    output int    pending
);

    int         bonus;
    int         penalty;
    int         gap;
    logic [7:0] query_syms [MAX_LEN];
    int         query_len;
    int         ref_len;
    int         column [MAX_LEN+1];
    logic       too_long_seen;
    logic       aligning;
    score_rec_t awaited_scores [$];
    int         fail_count;

    function automatic int clamp_score(input int v);
        if (v < -2048)
            return -2048;
        else if (v > 2047)
            return 2047;
        else
            return v;
    endfunction

    function automatic int edge_at(input int k);
        return clamp_score(-(k * gap));
    endfunction

    task automatic reload_edges();
        for (int i = 0; i <= query_len; i++)
            column[i] = edge_at(i);
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: alignment check: %s", $time, msg);
        fail_count++;
    endtask

    // One accepted input beat, applied to the predicted state.
    task automatic take_item(input logic func, input logic [7:0] sym, input logic last);
        int         diag;
        int         old;
        int         d;
        int         best;
        score_rec_t rec;
        if (func == FUNC_LOAD)
        begin
            // A load after the query has ended opens a new query.
            if (aligning)
            begin
                aligning      = 1'b0;
                query_len     = 0;
                ref_len       = 0;
                too_long_seen = 1'b0;
            end
            if (query_len < MAX_LEN)
            begin
                query_syms[query_len] = sym;
                query_len++;
            end
            else
                too_long_seen = 1'b1;
            if (last)
            begin
                reload_edges();
                ref_len  = 0;
                aligning = 1'b1;
            end
        end
        else if (aligning)
        begin
            if (ref_len < MAX_LEN)
            begin
                diag = column[0];
                ref_len++;
                column[0] = edge_at(ref_len);
                for (int i = 1; i <= query_len; i++)
                begin
                    old  = column[i];
                    d    = (query_syms[i-1] == sym) ? diag + bonus : diag - penalty;
                    best = column[i-1] - gap;
                    if (old - gap > best)
                        best = old - gap;
                    if (d > best)
                        best = d;
                    column[i] = clamp_score(best);
                    diag      = old;
                end
            end
            else
                too_long_seen = 1'b1;
            if (last)
            begin
                rec.score    = score_t'(column[query_len]);
                rec.too_long = too_long_seen;
                awaited_scores.push_back(rec);
                reload_edges();
                ref_len = 0;
            end
        end
    endtask

    task automatic take_result();
        score_rec_t want;
        if (awaited_scores.size() == 0)
            report_mismatch($sformatf("unexpected result: score %0d too_long %0b",
                                      $signed(result.score), result.too_long));
        else
        begin
            want = awaited_scores.pop_front();
            if (result.score !== want.score)
                report_mismatch($sformatf("score %0d, expected %0d",
                                          $signed(result.score), $signed(want.score)));
            if (result.too_long !== want.too_long)
                report_mismatch($sformatf("too_long %0b, expected %0b",
                                          result.too_long, want.too_long));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            bonus         = 1;
            penalty       = 1;
            gap           = 1;
            query_len     = 0;
            ref_len       = 0;
            too_long_seen = 1'b0;
            aligning      = 1'b0;
            foreach (column[i])
                column[i] = 0;
            awaited_scores.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MATCH_BONUS:      bonus   = int'(cfg.data);
                    REG_MISMATCH_PENALTY: penalty = int'(cfg.data);
                    REG_GAP_PENALTY:      gap     = int'(cfg.data);
                    default: ;
                endcase
            end
            // Results go first so that a beat taken in the same cycle cannot satisfy them.
            if (result.valid && result.ready)
                take_result();
            if (item.valid && item.ready)
                take_item(item.func, item.symbol, item.last);
        end
        pending    <= awaited_scores.size();
        mismatches <= fail_count;
    end

endmodule

>>> tb/tb_global_alignment_score.sv
// Testbench top for the global alignment score block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_global_alignment_score
    import gas_pkg::*;
    import gas_tb_pkg::*;
;

    localparam int MAX_LEN       = 64;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 225;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   items_done;

    gas_item_if   item_ch ();
    gas_result_if result_ch ();
    gas_cfg_if    cfg_ch ();

    global_alignment_score #(.MAX_LEN(MAX_LEN)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    gas_score_checker #(.MAX_LEN(MAX_LEN)) score_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side back-pressure.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("global_alignment_score verification failed");
        $finish;
    end

    function automatic logic [7:0] pick_symbol(input int alphabet);
        return 8'($urandom_range(alphabet - 1));
    endfunction

    // Presents one beat and returns at the edge that accepts it; valid is left high.
    task automatic send_symbol(input logic func, input logic [7:0] sym, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.func   <= func;
        item_ch.symbol <= sym;
        item_ch.last   <= last;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [3:0] bonus, input logic [3:0] penalty,
                                  input logic [3:0] gap);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [3:0]           val [3];
        idx = '{REG_MATCH_BONUS, REG_MISMATCH_PENALTY, REG_GAP_PENALTY};
        val = '{bonus, penalty, gap};
        for (int i = 0; i < 3; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits for every expected score, then lets the cell row drain. The first edge lets
    // the checker's count catch up with a beat taken at the edge this task starts on.
    task automatic settle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (MAX_LEN + 8)
            @(posedge clk);
    endtask

    // One query followed by a few references against it. Now and then a stream beat
    // lands in the middle of the load, or a reference is dropped before its last beat.
    task automatic run_episode();
        int   alphabet;
        int   r;
        int   qlen;
        int   rlen;
        int   nrefs;
        logic drop;
        alphabet = ($urandom_range(3) == 0) ? 256 : 4;
        r = $urandom_range(99);
        if (r < 85)
            qlen = $urandom_range(16, 1);
        else if (r < 95)
            qlen = $urandom_range(64, 56);
        else
            qlen = $urandom_range(70, 65);
        for (int i = 0; i < qlen; i++)
        begin
            if (i > 0 && $urandom_range(19) == 0)
                send_symbol(FUNC_STREAM, pick_symbol(alphabet), 1'($urandom_range(1)));
            send_symbol(FUNC_LOAD, pick_symbol(alphabet), i == qlen - 1);
        end
        items_done += qlen;
        nrefs = $urandom_range(4, 1);
        for (int n = 0; n < nrefs; n++)
        begin
            r = $urandom_range(99);
            if (r < 80)
                rlen = $urandom_range(20, 1);
            else if (r < 92)
                rlen = $urandom_range(64, 56);
            else
                rlen = $urandom_range(72, 65);
            drop = ($urandom_range(19) == 0);
            for (int i = 0; i < rlen; i++)
                send_symbol(FUNC_STREAM, pick_symbol(alphabet), i == rlen - 1 && !drop);
            items_done += rlen;
            if (drop)
                return;
        end
    endtask

    initial
    begin
        item_t      opening [14];
        logic [3:0] bonus_set [SEGMENTS];
        logic [3:0] penalty_set [SEGMENTS];
        logic [3:0] gap_set [SEGMENTS];

        // Stream before any query, a match, a second reference, a reference cut short by
        // a new query, and a stream beat while that query is still loading.
        opening = '{
            {FUNC_STREAM, 8'h41, 1'b0}, {FUNC_STREAM, 8'h42, 1'b1},
            {FUNC_LOAD,   8'h00, 1'b0}, {FUNC_LOAD,   8'hFF, 1'b1},
            {FUNC_STREAM, 8'h00, 1'b0}, {FUNC_STREAM, 8'hFF, 1'b1},
            {FUNC_STREAM, 8'hFF, 1'b1}, {FUNC_STREAM, 8'h80, 1'b0},
            {FUNC_LOAD,   8'h41, 1'b0}, {FUNC_STREAM, 8'h41, 1'b1},
            {FUNC_LOAD,   8'h43, 1'b1}, {FUNC_STREAM, 8'h41, 1'b0},
            {FUNC_STREAM, 8'h43, 1'b0}, {FUNC_STREAM, 8'h55, 1'b1}
        };
        bonus_set   = '{4'd15, 4'd0, 4'd2, 4'd15, 4'd0,  4'd0};
        penalty_set = '{4'd15, 4'd0, 4'd3, 4'd0,  4'd15, 4'd0};
        gap_set     = '{4'd15, 4'd0, 4'd1, 4'd0,  4'd15, 4'd0};
        bonus_set[SEGMENTS-1]   = 4'($urandom_range(15));
        penalty_set[SEGMENTS-1] = 4'($urandom_range(15));
        gap_set[SEGMENTS-1]     = 4'($urandom_range(15));

        rst_n          <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.func   <= FUNC_LOAD;
        item_ch.symbol <= 8'h00;
        item_ch.last   <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= REG_MATCH_BONUS;
        cfg_ch.data    <= 4'd0;
        send_idle_pct = 37;
        recv_idle_pct = 79;
        items_done    = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_symbol(opening[i].func, opening[i].symbol, opening[i].last);
        item_ch.valid <= 1'b0;

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 37;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            apply_settings(bonus_set[seg], penalty_set[seg], gap_set[seg]);
            while (items_done < (seg + 1) * SEGMENT_ITEMS)
                run_episode();
            item_ch.valid <= 1'b0;
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("global_alignment_score verification clean");
        else
            $display("global_alignment_score verification failed");
        $finish;
    end

endmodule
